// ===== rtl/dsky_pkg.sv =====
`default_nettype none

package dsky_pkg;

   localparam int unsigned ROW_SLOTS  = 15;
   localparam int unsigned PAIR_SLOTS = 6;
   localparam int unsigned SIGN_BITS  = 6;

   localparam logic [3:0] BLANK_DIGIT = 4'd10;

   localparam logic [8:0] CH_RELAY = 9'd8;
   localparam logic [8:0] CH_LAMP  = 9'd9;
   localparam logic [8:0] CH_FLAGS = 9'd115;

   localparam logic [3:0] LOC_ROW3_D34   = 4'd1;
   localparam logic [3:0] LOC_ROW3_D12   = 4'd2;
   localparam logic [3:0] LOC_ROW3_D0    = 4'd3;
   localparam logic [3:0] LOC_ROW2_D23   = 4'd4;
   localparam logic [3:0] LOC_ROW2_D01   = 4'd5;
   localparam logic [3:0] LOC_ROW1_D34   = 4'd6;
   localparam logic [3:0] LOC_ROW1_D12   = 4'd7;
   localparam logic [3:0] LOC_ROW1_D0    = 4'd8;
   localparam logic [3:0] LOC_NOUN       = 4'd9;
   localparam logic [3:0] LOC_VERB       = 4'd10;
   localparam logic [3:0] LOC_PROG       = 4'd11;

   localparam int unsigned LAMP_BIT  = 1;
   localparam int unsigned BLANK_BIT = 5;

   typedef struct packed {
      logic [ROW_SLOTS-1:0]  row_we;
      logic [ROW_SLOTS-1:0]  row_left;
      logic [PAIR_SLOTS-1:0] pair_we;
      logic [PAIR_SLOTS-1:0] pair_left;
      logic [SIGN_BITS-1:0]  sign_we;
      logic                  sign;
      logic [3:0]            left_digit;
      logic [3:0]            right_digit;
      logic                  lamp_we;
      logic                  lamp;
      logic                  flags_we;
      logic [15:0]           flags;
      logic                  refresh;
   } panel_write_type;

   function automatic logic [3:0] seg_decode(input logic [4:0] code);
      logic [3:0] digit;
      case (code)
         5'd3:    digit = 4'd1;
         5'd15:   digit = 4'd4;
         5'd19:   digit = 4'd7;
         5'd21:   digit = 4'd0;
         5'd25:   digit = 4'd2;
         5'd27:   digit = 4'd3;
         5'd28:   digit = 4'd6;
         5'd29:   digit = 4'd8;
         5'd30:   digit = 4'd5;
         5'd31:   digit = 4'd9;
         default: digit = BLANK_DIGIT;
      endcase
      return digit;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dsky_display_relay_decoder.sv =====
// Display relay decoder: takes one output-channel write per beat (channel, value) and
// answers each with one snapshot of the display panel plus a refresh flag. Relay words on
// channel 8 are decoded through the segment table and written into the digit and sign
// registers, channel 9 sets the activity lamp, channel 115 stores the flag word and blanks
// or shows verb and noun. The panel registers themselves form the result register, so a
// beat's result appears in the cycle after acceptance and a new beat is taken every cycle while
// the result side keeps up; the channel/location decode and the table lookup sit
// combinationally in front of the panel registers.
`default_nettype none

module dsky_display_relay_decoder
   import dsky_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [8:0]   req_channel,
   input  wire logic [15:0]  req_value,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_refresh,
   output logic [7:0]        rsp_prog_digits,
   output logic [7:0]        rsp_verb_digits,
   output logic [7:0]        rsp_noun_digits,
   output logic              rsp_verb_noun_lit,
   output logic [19:0]       rsp_row_one_digits,
   output logic [19:0]       rsp_row_two_digits,
   output logic [19:0]       rsp_row_three_digits,
   output logic [5:0]        rsp_row_signs,
   output logic              rsp_activity_lamp,
   output logic [15:0]       rsp_flag_word
);

   panel_write_type wr;
   logic            accept;
   logic            valid_ff;
   logic            valid_in;
   logic            refresh_ff;

   assign req_ready = ~valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign valid_in  = accept | (valid_ff & ~rsp_ready);

   dsky_relay_decode u_decode (
      .channel (req_channel),
      .value   (req_value),
      .wr      (wr)
   );

   dsky_panel_state u_state (
      .clock            (clock),
      .reset            (reset),
      .wr_en            (accept),
      .wr               (wr),
      .prog_digits      (rsp_prog_digits),
      .verb_digits      (rsp_verb_digits),
      .noun_digits      (rsp_noun_digits),
      .verb_noun_lit    (rsp_verb_noun_lit),
      .row_one_digits   (rsp_row_one_digits),
      .row_two_digits   (rsp_row_two_digits),
      .row_three_digits (rsp_row_three_digits),
      .row_signs        (rsp_row_signs),
      .activity_lamp    (rsp_activity_lamp),
      .flag_word        (rsp_flag_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         refresh_ff <= wr.refresh;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_refresh = refresh_ff;

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no result");

   a_lamp_no_refresh: assert property (@(posedge clock) disable iff (reset)
      (accept && req_channel == CH_LAMP) |=> !rsp_refresh)
      else $error("lamp write flagged refresh");

   a_flags_update: assert property (@(posedge clock) disable iff (reset)
      (accept && req_channel == CH_FLAGS) |=>
         (rsp_refresh && rsp_flag_word == $past(req_value)
          && rsp_verb_noun_lit == !$past(req_value[BLANK_BIT])))
      else $error("flag write not reflected in result");

endmodule

`default_nettype wire

// ===== rtl/dsky_relay_decode.sv =====
`default_nettype none

module dsky_relay_decode
   import dsky_pkg::*;
(
   input  wire logic [8:0]      channel,
   input  wire logic [15:0]     value,
   output panel_write_type      wr
);

   logic [3:0] loc;

   assign loc = value[14:11];

   always_comb begin
      wr             = '0;
      wr.sign        = value[10];
      wr.left_digit  = seg_decode(value[9:5]);
      wr.right_digit = seg_decode(value[4:0]);
      wr.lamp        = value[LAMP_BIT];
      wr.flags       = value;
      unique case (channel)
         CH_RELAY: begin
            wr.refresh = 1'b1;
            unique case (loc)
               LOC_ROW3_D34: begin
                  wr.row_we[14] = 1'b1;
                  wr.row_we[13] = 1'b1;
                  wr.row_left[13] = 1'b1;
                  wr.sign_we[0] = 1'b1;
               end
               LOC_ROW3_D12: begin
                  wr.row_we[12] = 1'b1;
                  wr.row_we[11] = 1'b1;
                  wr.row_left[11] = 1'b1;
                  wr.sign_we[1] = 1'b1;
               end
               LOC_ROW3_D0: begin
                  wr.row_we[10] = 1'b1;
                  wr.row_we[9] = 1'b1;
                  wr.row_left[9] = 1'b1;
               end
               LOC_ROW2_D23: begin
                  wr.row_we[8] = 1'b1;
                  wr.row_we[7] = 1'b1;
                  wr.row_left[7] = 1'b1;
                  wr.sign_we[2] = 1'b1;
               end
               LOC_ROW2_D01: begin
                  wr.row_we[6] = 1'b1;
                  wr.row_we[5] = 1'b1;
                  wr.row_left[5] = 1'b1;
                  wr.sign_we[3] = 1'b1;
               end
               LOC_ROW1_D34: begin
                  wr.row_we[4] = 1'b1;
                  wr.row_we[3] = 1'b1;
                  wr.row_left[3] = 1'b1;
                  wr.sign_we[4] = 1'b1;
               end
               LOC_ROW1_D12: begin
                  wr.row_we[2] = 1'b1;
                  wr.row_we[1] = 1'b1;
                  wr.row_left[1] = 1'b1;
                  wr.sign_we[5] = 1'b1;
               end
               LOC_ROW1_D0: begin
                  wr.row_we[0] = 1'b1;
               end
               LOC_NOUN: begin
                  wr.pair_we[4] = 1'b1;
                  wr.pair_we[5] = 1'b1;
                  wr.pair_left[4] = 1'b1;
               end
               LOC_VERB: begin
                  wr.pair_we[2] = 1'b1;
                  wr.pair_we[3] = 1'b1;
                  wr.pair_left[2] = 1'b1;
               end
               LOC_PROG: begin
                  wr.pair_we[0] = 1'b1;
                  wr.pair_we[1] = 1'b1;
                  wr.pair_left[0] = 1'b1;
               end
               default: begin
                  wr.refresh = 1'b0;
               end
            endcase
         end
         CH_LAMP: begin
            wr.lamp_we = 1'b1;
         end
         CH_FLAGS: begin
            wr.flags_we = 1'b1;
            wr.refresh  = 1'b1;
         end
         default: begin
            wr.refresh = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/dsky_panel_state.sv =====
`default_nettype none

module dsky_panel_state
   import dsky_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire panel_write_type  wr,
   output logic [7:0]            prog_digits,
   output logic [7:0]            verb_digits,
   output logic [7:0]            noun_digits,
   output logic                  verb_noun_lit,
   output logic [19:0]           row_one_digits,
   output logic [19:0]           row_two_digits,
   output logic [19:0]           row_three_digits,
   output logic [5:0]            row_signs,
   output logic                  activity_lamp,
   output logic [15:0]           flag_word
);

   logic [3:0]  row_ff  [ROW_SLOTS];
   logic [3:0]  pair_ff [PAIR_SLOTS];
   logic [5:0]  sign_ff;
   logic        lit_ff;
   logic        lamp_ff;
   logic [15:0] flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_SLOTS; i++) begin
            row_ff[i] <= BLANK_DIGIT;
         end
         for (int i = 0; i < PAIR_SLOTS; i++) begin
            pair_ff[i] <= BLANK_DIGIT;
         end
         sign_ff  <= '0;
         lit_ff   <= 1'b1;
         lamp_ff  <= 1'b0;
         flags_ff <= '0;
      end else if (wr_en) begin
         for (int i = 0; i < ROW_SLOTS; i++) begin
            if (wr.row_we[i]) begin
               row_ff[i] <= wr.row_left[i] ? wr.left_digit : wr.right_digit;
            end
         end
         for (int i = 0; i < PAIR_SLOTS; i++) begin
            if (wr.pair_we[i]) begin
               pair_ff[i] <= wr.pair_left[i] ? wr.left_digit : wr.right_digit;
            end
         end
         for (int i = 0; i < SIGN_BITS; i++) begin
            if (wr.sign_we[i]) begin
               sign_ff[i] <= wr.sign;
            end
         end
         if (wr.lamp_we) begin
            lamp_ff <= wr.lamp;
         end
         if (wr.flags_we) begin
            flags_ff <= wr.flags;
            lit_ff   <= ~wr.flags[BLANK_BIT];
         end
      end
   end

   assign prog_digits      = {pair_ff[0], pair_ff[1]};
   assign verb_digits      = {pair_ff[2], pair_ff[3]};
   assign noun_digits      = {pair_ff[4], pair_ff[5]};
   assign verb_noun_lit    = lit_ff;
   assign row_one_digits   = {row_ff[0], row_ff[1], row_ff[2], row_ff[3], row_ff[4]};
   assign row_two_digits   = {row_ff[5], row_ff[6], row_ff[7], row_ff[8], row_ff[9]};
   assign row_three_digits = {row_ff[10], row_ff[11], row_ff[12], row_ff[13], row_ff[14]};
   assign row_signs        = sign_ff;
   assign activity_lamp    = lamp_ff;
   assign flag_word        = flags_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top
   import dsky_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0]   LOC_UNUSED_LOW  = 4'd0;
   localparam logic [3:0]   LOC_UNUSED_HIGH = 4'd15;
   localparam logic [8:0]   CH_LOWEST       = 9'd0;
   localparam logic [8:0]   CH_HIGHEST      = 9'h1FF;
   localparam int unsigned  ITEM_COUNT      = 1250;
   localparam int unsigned  REPORT_LIMIT    = 10;

   // nibble n holds the digit for segment code n
   localparam logic [127:0] SEG_MAP   = 128'h9586_3A2A_AA0A_7AAA_4AAA_AAAA_AAAA_1AAA;
   localparam logic [49:0]  LIT_CODES = {5'd3, 5'd15, 5'd19, 5'd21, 5'd25,
                                         5'd27, 5'd28, 5'd29, 5'd30, 5'd31};

   typedef struct packed {
      logic [8:0]  channel;
      logic [15:0] value;
   } chan_write_type;

   typedef struct packed {
      logic        refresh;
      logic [7:0]  prog;
      logic [7:0]  verb;
      logic [7:0]  noun;
      logic        vn_lit;
      logic [19:0] row_one;
      logic [19:0] row_two;
      logic [19:0] row_three;
      logic [5:0]  signs;
      logic        lamp;
      logic [15:0] flags;
   } panel_view_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [8:0]  req_channel = '0;
   logic [15:0] req_value   = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic        rsp_refresh;
   logic [7:0]  rsp_prog_digits;
   logic [7:0]  rsp_verb_digits;
   logic [7:0]  rsp_noun_digits;
   logic        rsp_verb_noun_lit;
   logic [19:0] rsp_row_one_digits;
   logic [19:0] rsp_row_two_digits;
   logic [19:0] rsp_row_three_digits;
   logic [5:0]  rsp_row_signs;
   logic        rsp_activity_lamp;
   logic [15:0] rsp_flag_word;

   chan_write_type write_queue[$];
   panel_view_type panel_expect_q[$];
   panel_view_type want;
   chan_write_type next_write;

   logic [3:0]  row_digits [15];
   logic [3:0]  pair_digits [6];
   logic [5:0]  sign_bits;
   logic        vn_shown;
   logic        lamp_bit;
   logic [15:0] flag_bits;

   int          mismatch_count = 0;
   bit          beat_taken     = 1'b0;
   int          burst_left     = 1;
   int          gap_left       = 0;
   int          stall_cycles   = 0;
   logic [7:0]  stall_pattern  = 8'hFF;

   dsky_display_relay_decoder i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_channel          (req_channel),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_refresh          (rsp_refresh),
      .rsp_prog_digits      (rsp_prog_digits),
      .rsp_verb_digits      (rsp_verb_digits),
      .rsp_noun_digits      (rsp_noun_digits),
      .rsp_verb_noun_lit    (rsp_verb_noun_lit),
      .rsp_row_one_digits   (rsp_row_one_digits),
      .rsp_row_two_digits   (rsp_row_two_digits),
      .rsp_row_three_digits (rsp_row_three_digits),
      .rsp_row_signs        (rsp_row_signs),
      .rsp_activity_lamp    (rsp_activity_lamp),
      .rsp_flag_word        (rsp_flag_word)
   );

   function automatic logic [3:0] seg_digit(input logic [4:0] code);
      return SEG_MAP[{code, 2'b00} +: 4];
   endfunction

   function automatic panel_view_type apply_write(input logic [8:0] ch,
                                                  input logic [15:0] val);
      logic [3:0]     loc;
      logic [3:0]     left_d;
      logic [3:0]     right_d;
      logic           sgn;
      panel_view_type view;
      loc          = val[14:11];
      sgn          = val[10];
      left_d       = seg_digit(val[9:5]);
      right_d      = seg_digit(val[4:0]);
      view.refresh = 1'b0;
      case (ch)
         CH_RELAY: begin
            view.refresh = 1'b1;
            case (loc)
               LOC_ROW3_D34: begin
                  row_digits[14] = right_d;
                  row_digits[13] = left_d;
                  sign_bits[0]   = sgn;
               end
               LOC_ROW3_D12: begin
                  row_digits[12] = right_d;
                  row_digits[11] = left_d;
                  sign_bits[1]   = sgn;
               end
               LOC_ROW3_D0: begin
                  row_digits[10] = right_d;
                  row_digits[9]  = left_d;
               end
               LOC_ROW2_D23: begin
                  row_digits[8] = right_d;
                  row_digits[7] = left_d;
                  sign_bits[2]  = sgn;
               end
               LOC_ROW2_D01: begin
                  row_digits[6] = right_d;
                  row_digits[5] = left_d;
                  sign_bits[3]  = sgn;
               end
               LOC_ROW1_D34: begin
                  row_digits[4] = right_d;
                  row_digits[3] = left_d;
                  sign_bits[4]  = sgn;
               end
               LOC_ROW1_D12: begin
                  row_digits[2] = right_d;
                  row_digits[1] = left_d;
                  sign_bits[5]  = sgn;
               end
               LOC_ROW1_D0: begin
                  row_digits[0] = right_d;
               end
               LOC_NOUN: begin
                  pair_digits[4] = left_d;
                  pair_digits[5] = right_d;
               end
               LOC_VERB: begin
                  pair_digits[2] = left_d;
                  pair_digits[3] = right_d;
               end
               LOC_PROG: begin
                  pair_digits[0] = left_d;
                  pair_digits[1] = right_d;
               end
               default: begin
                  view.refresh = 1'b0;
               end
            endcase
         end
         CH_LAMP: begin
            lamp_bit = val[LAMP_BIT];
         end
         CH_FLAGS: begin
            vn_shown     = ~val[BLANK_BIT];
            flag_bits    = val;
            view.refresh = 1'b1;
         end
         default: begin
         end
      endcase
      view.prog      = {pair_digits[0], pair_digits[1]};
      view.verb      = {pair_digits[2], pair_digits[3]};
      view.noun      = {pair_digits[4], pair_digits[5]};
      view.vn_lit    = vn_shown;
      view.row_one   = {row_digits[0], row_digits[1], row_digits[2], row_digits[3],
                        row_digits[4]};
      view.row_two   = {row_digits[5], row_digits[6], row_digits[7], row_digits[8],
                        row_digits[9]};
      view.row_three = {row_digits[10], row_digits[11], row_digits[12], row_digits[13],
                        row_digits[14]};
      view.signs     = sign_bits;
      view.lamp      = lamp_bit;
      view.flags     = flag_bits;
      return view;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp,
                              input logic [31:0] act);
      if (exp !== act) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", name, exp, act);
      end
   endtask

   function automatic logic [4:0] pick_code(input bit any_code);
      int idx;
      if (any_code)
         return 5'($urandom_range(0, 31));
      idx = $urandom_range(0, 9);
      return LIT_CODES[idx*5 +: 5];
   endfunction

   function automatic logic [15:0] make_relay(input logic top, input logic [3:0] loc,
                                              input logic sgn, input logic [4:0] left_c,
                                              input logic [4:0] right_c);
      return {top, loc, sgn, left_c, right_c};
   endfunction

   task automatic queue_write(input logic [8:0] ch, input logic [15:0] val);
      chan_write_type w;
      w.channel = ch;
      w.value   = val;
      write_queue.push_back(w);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // sender: bursts with gaps, hold payload until the beat is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || beat_taken)) begin
         if (gap_left > 0 || write_queue.size() == 0) begin
            if (gap_left > 0)
               gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            next_write = write_queue.pop_front();
            req_valid   <= 1'b1;
            req_channel <= next_write.channel;
            req_value   <= next_write.value;
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver: rotate a stall pattern, pick a new one now and then
   always @(negedge clock) begin
      if (stall_cycles == 0) begin
         stall_cycles = $urandom_range(16, 64);
         case ($urandom_range(0, 3))
            0: stall_pattern = 8'hFF;
            1: stall_pattern = 8'($urandom_range(0, 255)) | 8'h01;
            2: stall_pattern = 8'h01;
            default: stall_pattern = 8'($urandom_range(0, 255)) | 8'h80;
         endcase
      end
      stall_cycles = stall_cycles - 1;
      rsp_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 15; i++)
            row_digits[i] = BLANK_DIGIT;
         for (int i = 0; i < 6; i++)
            pair_digits[i] = BLANK_DIGIT;
         sign_bits  = '0;
         vn_shown   = 1'b1;
         lamp_bit   = 1'b0;
         flag_bits  = '0;
         beat_taken = 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (panel_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result beat with nothing expected");
            end else begin
               want = panel_expect_q.pop_front();
               check_field("refresh", 32'(want.refresh), 32'(rsp_refresh));
               check_field("prog_digits", 32'(want.prog), 32'(rsp_prog_digits));
               check_field("verb_digits", 32'(want.verb), 32'(rsp_verb_digits));
               check_field("noun_digits", 32'(want.noun), 32'(rsp_noun_digits));
               check_field("verb_noun_lit", 32'(want.vn_lit), 32'(rsp_verb_noun_lit));
               check_field("row_one_digits", 32'(want.row_one), 32'(rsp_row_one_digits));
               check_field("row_two_digits", 32'(want.row_two), 32'(rsp_row_two_digits));
               check_field("row_three_digits", 32'(want.row_three),
                           32'(rsp_row_three_digits));
               check_field("row_signs", 32'(want.signs), 32'(rsp_row_signs));
               check_field("activity_lamp", 32'(want.lamp), 32'(rsp_activity_lamp));
               check_field("flag_word", 32'(want.flags), 32'(rsp_flag_word));
            end
         end
         beat_taken = req_valid && req_ready === 1'b1;
         if (beat_taken)
            panel_expect_q.push_back(apply_write(req_channel, req_value));
      end
   end

   initial begin
      logic [3:0] loc;
      int         pick;
      int         n;
      queue_write(CH_RELAY, make_relay(1'b0, LOC_UNUSED_LOW, 1'b1, 5'd21, 5'd3));
      for (loc = LOC_ROW3_D34; loc <= LOC_PROG; loc++)
         queue_write(CH_RELAY, make_relay(1'b0, loc, 1'b1, pick_code(1'b0),
                                          pick_code(1'b0)));
      queue_write(CH_RELAY, make_relay(1'b0, LOC_ROW3_D34, 1'b0, pick_code(1'b0),
                                       pick_code(1'b0)));
      queue_write(CH_RELAY, make_relay(1'b1, LOC_ROW1_D12, 1'b0, pick_code(1'b0),
                                       pick_code(1'b0)));
      queue_write(CH_RELAY, make_relay(1'b0, LOC_NOUN, 1'b1, 5'd0, 5'd31));
      queue_write(CH_RELAY, {LOC_UNUSED_HIGH, 12'hFFF} | 16'h8000);
      queue_write(CH_LAMP, 16'h0002);
      queue_write(CH_LAMP, 16'hFFFD);
      queue_write(CH_FLAGS, 16'h0020);
      queue_write(CH_FLAGS, 16'hFFDF);
      queue_write(CH_FLAGS, 16'hFFFF);
      queue_write(CH_FLAGS, 16'h0000);
      queue_write(CH_LOWEST, 16'hFFFF);
      queue_write(CH_HIGHEST, 16'hFFFF);

      for (n = 0; n < ITEM_COUNT; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 9) == 0)
               loc = 4'($urandom_range(0, 15));
            else
               loc = 4'($urandom_range(LOC_ROW3_D34, LOC_PROG));
            queue_write(CH_RELAY, make_relay(1'($urandom_range(0, 1)), loc,
                                             1'($urandom_range(0, 1)),
                                             pick_code(1'($urandom_range(0, 1))),
                                             pick_code(1'($urandom_range(0, 1)))));
         end else if (pick < 78) begin
            queue_write(CH_LAMP, 16'($urandom_range(0, 65535)));
         end else if (pick < 86) begin
            queue_write(CH_FLAGS, 16'($urandom_range(0, 65535)));
         end else begin
            queue_write(9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
         end
      end

      @(negedge clock);
      while (reset || write_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (panel_expect_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
